FILE: rtl/core/bpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants of the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int ORD_W  = 5;   // holds any order up to the largest order count
  localparam int WORD_W = 32;  // free map word width
  localparam int WORD_SH = 5;  // log2 of WORD_W

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_BAD_ORDER = 2'd1,
    ST_NO_SPACE  = 2'd2
  } status_t;

  typedef struct packed {
    logic       cmd;
    logic [3:0] order;
    logic [9:0] block_page;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] result_page;
  } rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SEEK,
    S_ORD_CHK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SPLIT,
    S_SPLIT_RD,
    S_SPLIT_WR,
    S_MERGE,
    S_MERGE_CHK,
    S_SET_RD,
    S_SET_WR,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    TGT_SELF,
    TGT_SPLIT,
    TGT_BUD
  } tgt_t;

  typedef struct packed {
    logic    load;
    logic    clr_wr;
    logic    seek_up;
    logic    scan_init;
    logic    scan_rd;
    logic    scan_next;
    logic    take_found;
    logic    step_down;
    tgt_t    tgt;
    logic    bit_wr;
    logic    bit_val;
    logic    merge_up;
    logic    idx_from_page;
    logic    st_wr;
    status_t st_val;
    logic    out_load;
  } ctl_t;

  typedef struct packed {
    logic bad_order;
    logic is_free;
    logic at_order;
    logic above_order;
    logic o_last;
    logic n_zero;
    logic free_oob;
    logic found;
    logic last_word;
    logic bit_set;
    logic bud_oob;
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/core/buddy_page_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Buddy page allocator with one free bit per block per order, kept in a
// word-wide RAM and walked by a sequencer.
// ----------------------------------------------------------------------------
//  channel | signals                     | direction | beat
//  --------+-----------------------------+-----------+---------------------
//  req     | req_valid, req_ready, req   | in        | cmd, order, page
//  rsp     | rsp_valid, rsp_ready, rsp   | out       | status, result_page
//
//  after reset a clearing pass writes every map word (64 words by default),
//  with req_ready low
//  one command at a time: the sequencer seeks up to the requested order;
//  an allocate then scans the map words of each order from there upward
//  and splits the found block down, a free merges with free buddies
//  upward (an invalid order goes straight to the response)
//  a waiting response holds the sequencer in its last state until taken
// ----------------------------------------------------------------------------
module buddy_page_allocator #(
  parameter int PAGE_COUNT  = 1024,
  parameter int ORDER_COUNT = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  bpa_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output bpa_pkg::rsp_t rsp
);

  bpa_pkg::ctl_t ctl;
  bpa_pkg::sts_t sts;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .ctl       (ctl),
    .sts       (sts)
  );

  bpa_datapath #(
    .PAGE_COUNT  (PAGE_COUNT),
    .ORDER_COUNT (ORDER_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sts       (sts),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

FILE: rtl/core/bpa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/bpa_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_datapath
// Free map storage, order and index registers, scan logic and result register.
// ----------------------------------------------------------------------------
module bpa_datapath #(
  parameter int PAGE_COUNT  = 1024,
  parameter int ORDER_COUNT = 11
) (
  input  logic           clk,
  input  logic           rst,
  input  bpa_pkg::ctl_t  ctl,
  output bpa_pkg::sts_t  sts,
  input  bpa_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output bpa_pkg::rsp_t  rsp
);

  localparam int WORDS = (2 * PAGE_COUNT + bpa_pkg::WORD_W - 1) / bpa_pkg::WORD_W;
  localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int BA    = $clog2(2 * PAGE_COUNT + 1);
  localparam int BAW   = (BA < 6) ? 6 : BA;
  localparam int LW    = (BAW > 10) ? BAW : 10;
  localparam logic [BAW-1:0] PC = BAW'(PAGE_COUNT);
  localparam logic [bpa_pkg::ORD_W-1:0] OC = bpa_pkg::ORD_W'(ORDER_COUNT);
  localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);

  // latched command
  logic                      cmd;
  logic [3:0]                order;
  logic [9:0]                pgi;
  // walk registers
  logic [bpa_pkg::ORD_W-1:0] o;
  logic [BAW-1:0]            base;
  logic [BAW-1:0]            idx;
  logic [WAW-1:0]            w;
  logic [WAW-1:0]            clr_cnt;
  bpa_pkg::status_t          st;

  logic                      ram_we;
  logic [WAW-1:0]            ram_waddr;
  logic [bpa_pkg::WORD_W-1:0] ram_wdata;
  logic [WAW-1:0]            ram_raddr;
  logic [bpa_pkg::WORD_W-1:0] rdata;

  logic [BAW-1:0]            n;
  logic [BAW-1:0]            n_dn;
  logic [BAW-1:0]            endm1;
  logic [WAW-1:0]            lo_w;
  logic [WAW-1:0]            hi_w;
  logic [bpa_pkg::WORD_W-1:0] lo_mask;
  logic [bpa_pkg::WORD_W-1:0] hi_mask;
  logic [bpa_pkg::WORD_W-1:0] cand;
  logic [4:0]                pos;
  logic [BAW-1:0]            g;
  logic [BAW-1:0]            tb;
  logic [BAW-1:0]            bud;
  logic [bpa_pkg::WORD_W-1:0] bit_word;
  logic [bpa_pkg::ORD_W:0]   o_inc;
  logic [LW-1:0]             page_wide;

  function automatic logic [WAW-1:0] word_of(input logic [BAW-1:0] b);
    logic [BAW-1:0] s;
    s = b >> bpa_pkg::WORD_SH;
    return s[WAW-1:0];
  endfunction

  assign n     = PC >> o;
  assign n_dn  = PC >> (o - 1'b1);
  assign endm1 = base + n - 1'b1;
  assign lo_w  = word_of(base);
  assign hi_w  = word_of(endm1);
  assign lo_mask = (w == lo_w) ? ({bpa_pkg::WORD_W{1'b1}} << base[4:0])
                               : {bpa_pkg::WORD_W{1'b1}};
  assign hi_mask = (w == hi_w) ? ({bpa_pkg::WORD_W{1'b1}} >> (5'd31 - endm1[4:0]))
                               : {bpa_pkg::WORD_W{1'b1}};
  assign cand  = rdata & lo_mask & hi_mask;

  // lowest set bit of the masked word
  always_comb begin
    pos = '0;
    for (int i = bpa_pkg::WORD_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pos = 5'(i);
      end
    end
  end

  assign g   = (BAW'(w) << bpa_pkg::WORD_SH) + BAW'(pos);
  assign bud = idx ^ BAW'(1);

  always_comb begin
    case (ctl.tgt)
      bpa_pkg::TGT_SPLIT: tb = base + idx + BAW'(1);
      bpa_pkg::TGT_BUD:   tb = base + bud;
      default:            tb = base + idx;
    endcase
  end

  always_comb begin
    bit_word = rdata;
    bit_word[tb[4:0]] = ctl.bit_val;
  end

  assign o_inc = {1'b0, o} + 1'b1;

  // ram ports
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = word_of(tb);
    ram_wdata = bit_word;
    if (ctl.clr_wr) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = '0;
    end else if (ctl.take_found) begin
      ram_we    = 1'b1;
      ram_waddr = w;
      ram_wdata = rdata & ~(bpa_pkg::WORD_W'(1) << pos);
    end else if (ctl.bit_wr) begin
      ram_we    = 1'b1;
    end
  end

  assign ram_raddr = ctl.scan_rd ? w : word_of(tb);

  bpa_ram #(
    .WIDTH (bpa_pkg::WORD_W),
    .DEPTH (WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (ctl.clr_wr) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd   <= req.cmd;
      order <= req.order;
      pgi   <= req.block_page >> req.order;
      o     <= '0;
      base  <= '0;
      st    <= bpa_pkg::ST_DONE;
    end else begin
      if (ctl.seek_up || ctl.merge_up) begin
        o    <= o_inc[bpa_pkg::ORD_W-1:0];
        base <= base + n;
      end
      if (ctl.step_down) begin
        o    <= o - 1'b1;
        base <= base - n_dn;
      end
      if (ctl.st_wr) begin
        st <= ctl.st_val;
      end
    end
    if (ctl.scan_init) begin
      w <= lo_w;
    end else if (ctl.scan_next) begin
      w <= w + 1'b1;
    end
    if (ctl.idx_from_page) begin
      idx <= BAW'(pgi);
    end else if (ctl.take_found) begin
      idx <= g - base;
    end else if (ctl.step_down) begin
      idx <= idx << 1;
    end else if (ctl.merge_up) begin
      idx <= idx >> 1;
    end
  end

  // result register
  assign sts.out_free = !rsp_valid || rsp_ready;
  assign page_wide    = LW'(idx) << order;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      rsp.status      <= st;
      rsp.result_page <= (st == bpa_pkg::ST_DONE && cmd == bpa_pkg::CMD_ALLOC)
                         ? page_wide[9:0] : 10'd0;
    end
  end

  assign sts.bad_order   = {1'b0, order} >= OC;
  assign sts.is_free     = (cmd == bpa_pkg::CMD_FREE);
  assign sts.at_order    = (o == {1'b0, order});
  assign sts.above_order = (o > {1'b0, order});
  assign sts.o_last      = (o_inc >= {1'b0, OC});
  assign sts.n_zero      = (n == '0);
  assign sts.free_oob    = LW'(pgi) >= LW'(n);
  assign sts.found       = (cand != '0);
  assign sts.last_word   = (w == hi_w);
  assign sts.bit_set     = rdata[tb[4:0]];
  assign sts.bud_oob     = (bud >= n);
  assign sts.clr_last    = (clr_cnt == LAST_WORD);

endmodule

FILE: rtl/core/bpa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_ctrl
// Command sequencer: clear pass, order seek, scan, split and merge walks.
// ----------------------------------------------------------------------------
module bpa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output bpa_pkg::ctl_t ctl,
  input  bpa_pkg::sts_t sts
);

  bpa_pkg::state_t state;
  bpa_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpa_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.tgt    = bpa_pkg::TGT_SELF;
    ctl.st_val = bpa_pkg::ST_DONE;
    req_ready  = 1'b0;
    case (state)
      bpa_pkg::S_CLEAR: begin
        ctl.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_next = bpa_pkg::S_IDLE;
        end
      end
      bpa_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          ctl.load   = 1'b1;
          state_next = bpa_pkg::S_CHECK;
        end
      end
      bpa_pkg::S_CHECK: begin
        if (sts.bad_order) begin
          ctl.st_wr  = 1'b1;
          ctl.st_val = bpa_pkg::ST_BAD_ORDER;
          state_next = bpa_pkg::S_FINISH;
        end else begin
          state_next = bpa_pkg::S_SEEK;
        end
      end
      bpa_pkg::S_SEEK: begin
        if (!sts.at_order) begin
          ctl.seek_up = 1'b1;
        end else if (!sts.is_free) begin
          state_next = bpa_pkg::S_ORD_CHK;
        end else if (sts.free_oob) begin
          state_next = bpa_pkg::S_FINISH;
        end else begin
          ctl.idx_from_page = 1'b1;
          state_next        = bpa_pkg::S_MERGE;
        end
      end
      bpa_pkg::S_ORD_CHK: begin
        // higher orders hold no more blocks, so none of them has space either
        if (sts.n_zero) begin
          ctl.st_wr  = 1'b1;
          ctl.st_val = bpa_pkg::ST_NO_SPACE;
          state_next = bpa_pkg::S_FINISH;
        end else begin
          ctl.scan_init = 1'b1;
          state_next    = bpa_pkg::S_SCAN_RD;
        end
      end
      bpa_pkg::S_SCAN_RD: begin
        ctl.scan_rd = 1'b1;
        state_next  = bpa_pkg::S_SCAN_CHK;
      end
      bpa_pkg::S_SCAN_CHK: begin
        if (sts.found) begin
          ctl.take_found = 1'b1;
          state_next     = bpa_pkg::S_SPLIT;
        end else if (!sts.last_word) begin
          ctl.scan_next = 1'b1;
          state_next    = bpa_pkg::S_SCAN_RD;
        end else if (sts.o_last) begin
          ctl.st_wr  = 1'b1;
          ctl.st_val = bpa_pkg::ST_NO_SPACE;
          state_next = bpa_pkg::S_FINISH;
        end else begin
          ctl.seek_up = 1'b1;
          state_next  = bpa_pkg::S_ORD_CHK;
        end
      end
      bpa_pkg::S_SPLIT: begin
        if (sts.above_order) begin
          ctl.step_down = 1'b1;
          state_next    = bpa_pkg::S_SPLIT_RD;
        end else begin
          state_next = bpa_pkg::S_FINISH;
        end
      end
      bpa_pkg::S_SPLIT_RD: begin
        ctl.tgt    = bpa_pkg::TGT_SPLIT;
        state_next = bpa_pkg::S_SPLIT_WR;
      end
      bpa_pkg::S_SPLIT_WR: begin
        // upper half goes free at the new order
        ctl.tgt     = bpa_pkg::TGT_SPLIT;
        ctl.bit_wr  = 1'b1;
        ctl.bit_val = 1'b1;
        state_next  = bpa_pkg::S_SPLIT;
      end
      bpa_pkg::S_MERGE: begin
        ctl.tgt = bpa_pkg::TGT_BUD;
        if (sts.o_last || sts.bud_oob) begin
          state_next = bpa_pkg::S_SET_RD;
        end else begin
          state_next = bpa_pkg::S_MERGE_CHK;
        end
      end
      bpa_pkg::S_MERGE_CHK: begin
        ctl.tgt = bpa_pkg::TGT_BUD;
        if (sts.bit_set) begin
          ctl.bit_wr   = 1'b1;
          ctl.bit_val  = 1'b0;
          ctl.merge_up = 1'b1;
          state_next   = bpa_pkg::S_MERGE;
        end else begin
          state_next = bpa_pkg::S_SET_RD;
        end
      end
      bpa_pkg::S_SET_RD: begin
        ctl.tgt    = bpa_pkg::TGT_SELF;
        state_next = bpa_pkg::S_SET_WR;
      end
      bpa_pkg::S_SET_WR: begin
        ctl.tgt     = bpa_pkg::TGT_SELF;
        ctl.bit_wr  = 1'b1;
        ctl.bit_val = 1'b1;
        state_next  = bpa_pkg::S_FINISH;
      end
      bpa_pkg::S_FINISH: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = bpa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bpa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: tb/buddy_page_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_page_allocator_tb
// Drives allocate and free commands through the request channel and checks
// every response against a bitmap model of the buddy allocator.
// ----------------------------------------------------------------------------
module buddy_page_allocator_tb;

  localparam int PAGES  = 1024;
  localparam int ORDERS = 11;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_ready;
  bpa_pkg::req_t req = '0;
  logic          rsp_valid;
  logic          rsp_ready = 1'b0;
  bpa_pkg::rsp_t rsp;

  buddy_page_allocator u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always #2 clk = ~clk;

  // free bit per block per order
  bit            free_bits [ORDERS][PAGES];
  bpa_pkg::rsp_t expected_rsp [$];
  int            errors = 0;
  bit            stim_done = 1'b0;
  bit            hold_rsp = 1'b0;

  function automatic bpa_pkg::rsp_t alloc_or_free(bpa_pkg::req_t r);
    bpa_pkg::rsp_t res;
    int o;
    int idx;
    int bud;
    bit found;
    res = '0;
    found = 1'b0;
    idx = 0;
    if (r.order >= ORDERS) begin
      res.status = bpa_pkg::ST_BAD_ORDER;
      return res;
    end
    if (r.cmd == bpa_pkg::CMD_ALLOC) begin
      for (o = r.order; o < ORDERS && !found; o++) begin
        for (int i = 0; i < (PAGES >> o); i++) begin
          if (free_bits[o][i]) begin
            idx = i;
            found = 1'b1;
            break;
          end
        end
        if (found) break;
      end
      if (!found) begin
        res.status = bpa_pkg::ST_NO_SPACE;
        return res;
      end
      free_bits[o][idx] = 1'b0;
      while (o > r.order) begin
        o--;
        idx = idx << 1;
        free_bits[o][idx + 1] = 1'b1;
      end
      res.status = bpa_pkg::ST_DONE;
      res.result_page = 10'(idx << r.order);
      return res;
    end
    idx = int'(r.block_page) >> r.order;
    res.status = bpa_pkg::ST_DONE;
    if (idx >= (PAGES >> r.order)) return res;
    o = r.order;
    while (o + 1 < ORDERS) begin
      bud = idx ^ 1;
      if (bud >= (PAGES >> o) || !free_bits[o][bud]) break;
      free_bits[o][bud] = 1'b0;
      idx = idx >> 1;
      o++;
    end
    free_bits[o][idx] = 1'b1;
    return res;
  endfunction

  // valid stays high between back to back beats
  task automatic send_cmd(logic c, logic [3:0] ord, logic [9:0] pg);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= '{cmd: c, order: ord, block_page: pg};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    expected_rsp.push_back(alloc_or_free(req));
    @(negedge clk);
  endtask

  // response side, one wait per beat
  initial begin
    int gap;
    forever begin
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      while (hold_rsp) begin
        rsp_ready <= 1'b0;
        @(negedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!(rsp_valid && rsp_ready));
      @(negedge clk);
    end
  end

  // long receiver hold-off, counted here
  initial begin
    int cnt;
    @(negedge rst);
    repeat (2000) @(posedge clk);
    hold_rsp = 1'b1;
    for (cnt = 0; cnt < 300; cnt++) @(posedge clk);
    hold_rsp = 1'b0;
  end

  always @(posedge clk) begin
    bpa_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsp.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %h", $time, rsp);
        errors++;
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.status !== want.status)
          $display("%0t: status expected %0d actual %0d", $time, want.status, rsp.status);
        if (rsp.result_page !== want.result_page)
          $display("%0t: result_page expected %0d actual %0d", $time,
                   want.result_page, rsp.result_page);
        if (rsp !== want) errors++;
      end
    end
  end

  typedef struct {
    logic          c;
    logic [3:0]    ord;
    logic [9:0]    pg;
    bit            chk;
    bpa_pkg::rsp_t want;
  } dir_row_t;

  dir_row_t dir_rows [] = '{
    '{bpa_pkg::CMD_ALLOC, 4'd0,  10'd0,   1, '{bpa_pkg::ST_NO_SPACE, 10'd0}},
    '{bpa_pkg::CMD_ALLOC, 4'd10, 10'd0,   1, '{bpa_pkg::ST_NO_SPACE, 10'd0}},
    '{bpa_pkg::CMD_ALLOC, 4'd11, 10'd0,   1, '{bpa_pkg::ST_BAD_ORDER, 10'd0}},
    '{bpa_pkg::CMD_FREE,  4'd15, 10'h3ff, 1, '{bpa_pkg::ST_BAD_ORDER, 10'd0}},
    '{bpa_pkg::CMD_FREE,  4'd10, 10'h3ff, 1, '{bpa_pkg::ST_DONE, 10'd0}},
    '{bpa_pkg::CMD_ALLOC, 4'd0,  10'h155, 1, '{bpa_pkg::ST_DONE, 10'd0}},
    '{bpa_pkg::CMD_ALLOC, 4'd3,  10'd0,   0, '{bpa_pkg::ST_DONE, 10'd0}},
    '{bpa_pkg::CMD_ALLOC, 4'd9,  10'd0,   0, '{bpa_pkg::ST_DONE, 10'd0}},
    '{bpa_pkg::CMD_ALLOC, 4'd9,  10'd0,   0, '{bpa_pkg::ST_DONE, 10'd0}},
    '{bpa_pkg::CMD_FREE,  4'd0,  10'd0,   0, '{bpa_pkg::ST_DONE, 10'd0}},
    '{bpa_pkg::CMD_FREE,  4'd0,  10'd0,   0, '{bpa_pkg::ST_DONE, 10'd0}},
    '{bpa_pkg::CMD_FREE,  4'd3,  10'h00f, 0, '{bpa_pkg::ST_DONE, 10'd0}},
    '{bpa_pkg::CMD_FREE,  4'd9,  10'h200, 0, '{bpa_pkg::ST_DONE, 10'd0}},
    '{bpa_pkg::CMD_FREE,  4'd9,  10'h2aa, 0, '{bpa_pkg::ST_DONE, 10'd0}},
    '{bpa_pkg::CMD_ALLOC, 4'd10, 10'd0,   1, '{bpa_pkg::ST_DONE, 10'd0}},
    '{bpa_pkg::CMD_ALLOC, 4'd10, 10'd0,   1, '{bpa_pkg::ST_NO_SPACE, 10'd0}},
    '{bpa_pkg::CMD_FREE,  4'd1,  10'h3fe, 0, '{bpa_pkg::ST_DONE, 10'd0}},
    '{bpa_pkg::CMD_ALLOC, 4'd0,  10'd0,   0, '{bpa_pkg::ST_DONE, 10'd0}},
    '{bpa_pkg::CMD_ALLOC, 4'd1,  10'd0,   0, '{bpa_pkg::ST_DONE, 10'd0}},
    '{bpa_pkg::CMD_ALLOC, 4'd0,  10'd0,   0, '{bpa_pkg::ST_DONE, 10'd0}},
    '{bpa_pkg::CMD_FREE,  4'd4,  10'h3f0, 0, '{bpa_pkg::ST_DONE, 10'd0}}
  };

  initial begin
    logic [9:0] pg;
    logic [3:0] ord;
    logic       c;
    int         sel;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].chk) begin
        send_cmd(dir_rows[i].c, dir_rows[i].ord, dir_rows[i].pg);
        if (expected_rsp[$] !== dir_rows[i].want) begin
          $display("%0t: table row %0d expected %h actual %h", $time, i,
                   dir_rows[i].want, expected_rsp[$]);
          errors++;
        end
      end else begin
        send_cmd(dir_rows[i].c, dir_rows[i].ord, dir_rows[i].pg);
      end
    end
    for (int n = 0; n < 650; n++) begin
      sel = $urandom_range(0, 99);
      pg = 10'($urandom);
      if (sel < 4) begin
        ord = 4'($urandom_range(11, 15));
        c = 1'($urandom);
      end else begin
        ord = 4'($urandom_range(0, 10));
        if (sel > 60) ord = 4'($urandom_range(0, 3));
        c = (sel < 50) ? bpa_pkg::CMD_FREE : bpa_pkg::CMD_ALLOC;
        if (sel < 10) pg = 10'($urandom_range(0, 15));
      end
      send_cmd(c, ord, pg);
    end
    req_valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
